// ----- rtl/core/aabc_pkg.sv -----
`default_nettype none
package aabc_pkg;

    localparam int POS_W   = 24;
    localparam int MAG_W   = 23;
    localparam int ERR_W   = 25;
    localparam int PROD_W  = 29;
    localparam int CRAWL_W = 20;
    localparam int CALC_W  = 32;
    localparam int IDX_W   = 2;
    localparam int Q_FRAC  = 20;

    localparam logic [14:0] CRAWL_COEF = 15'd10486;

    localparam logic [IDX_W-1:0] REG_GAIN_POS  = 2'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_NEG  = 2'd1;
    localparam logic [IDX_W-1:0] REG_LIMIT_POS = 2'd2;
    localparam logic [IDX_W-1:0] REG_LIMIT_NEG = 2'd3;

    localparam logic [MAG_W-1:0] GAIN_RESET  = 23'd1049;
    localparam logic [MAG_W-1:0] LIMIT_RESET = 23'd10486;

    localparam logic signed [CALC_W-1:0] S24_MAX = 32'sh007F_FFFF;
    localparam logic signed [CALC_W-1:0] S24_MIN = -32'sh0080_0000;

    typedef struct packed {
        logic [MAG_W-1:0] gain_pos;
        logic [MAG_W-1:0] gain_neg;
        logic [MAG_W-1:0] limit_pos;
        logic [MAG_W-1:0] limit_neg;
    } cfg_t;

    typedef struct packed {
        logic [PROD_W-1:0]         prod_pos;
        logic [PROD_W-1:0]         prod_neg;
        logic signed [CRAWL_W-1:0] crawl;
        logic                      fwd;
        logic                      far_pos;
        logic                      far_neg;
    } prod_t;

    function automatic logic signed [POS_W-1:0] sat24(input logic signed [CALC_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > S24_MAX) begin
            r = S24_MAX[POS_W-1:0];
        end else if (v < S24_MIN) begin
            r = S24_MIN[POS_W-1:0];
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/aabc_cfg.sv -----
`default_nettype none
module aabc_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    input  wire logic [aabc_pkg::IDX_W-1:0]      cfg_index,
    input  wire logic [aabc_pkg::MAG_W-1:0]      cfg_data,
    output aabc_pkg::cfg_t                       cfg
);

    aabc_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_pos  <= aabc_pkg::GAIN_RESET;
            cfg_reg.gain_neg  <= aabc_pkg::GAIN_RESET;
            cfg_reg.limit_pos <= aabc_pkg::LIMIT_RESET;
            cfg_reg.limit_neg <= aabc_pkg::LIMIT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                aabc_pkg::REG_GAIN_POS:  cfg_reg.gain_pos  <= cfg_data;
                aabc_pkg::REG_GAIN_NEG:  cfg_reg.gain_neg  <= cfg_data;
                aabc_pkg::REG_LIMIT_POS: cfg_reg.limit_pos <= cfg_data;
                aabc_pkg::REG_LIMIT_NEG: cfg_reg.limit_neg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ----- rtl/core/aabc_prod.sv -----
`default_nettype none
module aabc_prod (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [aabc_pkg::POS_W-1:0]   s_current_position,
    input  wire logic signed [aabc_pkg::POS_W-1:0]   s_target_position,
    input  wire logic [aabc_pkg::MAG_W-1:0]          s_margin_pos,
    input  wire logic [aabc_pkg::MAG_W-1:0]          s_margin_neg,
    input  wire aabc_pkg::cfg_t                      cfg,
    input  wire logic                                take,
    output logic                                     prod_valid,
    output aabc_pkg::prod_t                          prod
);

    localparam int GAIN_W = aabc_pkg::ERR_W;
    localparam int PP_W   = aabc_pkg::MAG_W + GAIN_W + 1;
    localparam int CP_W   = aabc_pkg::ERR_W + 15;

    logic                              valid_reg;
    aabc_pkg::prod_t                   prod_reg;
    aabc_pkg::prod_t                   prod_next;
    logic signed [aabc_pkg::ERR_W-1:0] err;
    logic [aabc_pkg::ERR_W-2:0]        err_abs;
    logic [GAIN_W-1:0]                 gain;
    logic [PP_W-1:0]                   pp_pos;
    logic [PP_W-1:0]                   pp_neg;
    logic signed [CP_W-1:0]            cp;
    logic signed [aabc_pkg::ERR_W:0]   mpos_s;
    logic signed [aabc_pkg::ERR_W:0]   mneg_s;
    logic                              load;

    always_comb begin
        err     = aabc_pkg::ERR_W'(s_target_position) - aabc_pkg::ERR_W'(s_current_position);
        err_abs = (aabc_pkg::ERR_W - 1)'(err[aabc_pkg::ERR_W-1] ? -err : err);
        gain    = {err_abs, 1'b0};
        pp_pos  = PP_W'(cfg.gain_pos) * PP_W'(gain) + PP_W'(1 << (aabc_pkg::Q_FRAC - 1));
        pp_neg  = PP_W'(cfg.gain_neg) * PP_W'(gain) + PP_W'(1 << (aabc_pkg::Q_FRAC - 1));
        cp      = CP_W'(err) * signed'(CP_W'(aabc_pkg::CRAWL_COEF))
                  + signed'(CP_W'(1 << (aabc_pkg::Q_FRAC - 1)));
        mpos_s  = signed'((aabc_pkg::ERR_W + 1)'(s_margin_pos));
        mneg_s  = signed'((aabc_pkg::ERR_W + 1)'(s_margin_neg));

        prod_next.prod_pos = pp_pos[aabc_pkg::Q_FRAC +: aabc_pkg::PROD_W];
        prod_next.prod_neg = pp_neg[aabc_pkg::Q_FRAC +: aabc_pkg::PROD_W];
        prod_next.crawl    = cp[aabc_pkg::Q_FRAC +: aabc_pkg::CRAWL_W];
        prod_next.fwd      = err > 0;
        prod_next.far_pos  = (aabc_pkg::ERR_W + 1)'(err) > mpos_s;
        prod_next.far_neg  = (aabc_pkg::ERR_W + 1)'(err) < -mneg_s;
    end

    assign s_ready = !valid_reg || take;
    assign load    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = valid_reg;
    assign prod       = prod_reg;

endmodule
`default_nettype wire

// ----- rtl/core/aabc_ctrl.sv -----
`default_nettype none
module aabc_ctrl (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                prod_valid,
    input  wire aabc_pkg::prod_t                     prod,
    input  wire aabc_pkg::cfg_t                      cfg,
    output logic                                     take,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [aabc_pkg::POS_W-1:0]        m_accel_out,
    output logic signed [aabc_pkg::POS_W-1:0]        m_speed_out,
    output logic                                     m_braking
);

    localparam int W = aabc_pkg::CALC_W;

    logic                              m_valid_reg;
    logic signed [aabc_pkg::POS_W-1:0] speed_reg;
    logic signed [aabc_pkg::POS_W-1:0] speed_next;
    logic                              brake_reg;
    logic                              brake_next;
    logic signed [aabc_pkg::POS_W-1:0] accel_reg;
    logic signed [aabc_pkg::POS_W-1:0] accel_next;

    logic signed [W-1:0] spd;
    logic signed [W-1:0] pp;
    logic signed [W-1:0] pn;
    logic signed [W-1:0] crawl;
    logic signed [W-1:0] gp;
    logic signed [W-1:0] gn;
    logic signed [W-1:0] lp;
    logic signed [W-1:0] ln;
    logic signed [W-1:0] acc;
    logic signed [W-1:0] bacc;
    logic signed [W-1:0] diff;

    always_comb begin
        spd   = W'(speed_reg);
        pp    = signed'(W'(prod.prod_pos));
        pn    = signed'(W'(prod.prod_neg));
        crawl = W'(prod.crawl);
        gp    = signed'(W'(cfg.gain_pos));
        gn    = signed'(W'(cfg.gain_neg));
        lp    = signed'(W'(cfg.limit_pos));
        ln    = signed'(W'(cfg.limit_neg));
        acc   = '0;
        bacc  = '0;
        diff  = '0;
        brake_next = brake_reg;

        if (brake_reg) begin
            if (spd > 0) begin
                bacc = W'(aabc_pkg::sat24(-(pp <<< 1)));
                acc  = bacc;
                if (spd + bacc <= 0) begin
                    brake_next = 1'b0;
                end
            end else if (spd < 0) begin
                bacc = W'(aabc_pkg::sat24(pn <<< 1));
                acc  = bacc;
                if (spd + bacc >= 0) begin
                    brake_next = 1'b0;
                end
            end else begin
                brake_next = 1'b0;
            end
        end else if (prod.fwd) begin
            if (spd > lp) begin
                acc = -pn;
            end else if (prod.far_pos) begin
                acc = pp;
            end else if (spd >= 0) begin
                if (spd > crawl) begin
                    diff = spd - crawl;
                    acc  = (diff < gp) ? -diff : -gp;
                end else begin
                    acc = crawl;
                end
            end else begin
                brake_next = 1'b1;
            end
        end else begin
            if (spd < -ln) begin
                acc = pp;
            end else if (prod.far_neg) begin
                acc = -pn;
            end else if (spd > 0) begin
                brake_next = 1'b1;
            end else if (spd < crawl) begin
                diff = crawl - spd;
                acc  = (diff < gn) ? diff : gn;
            end else begin
                acc = crawl;
            end
        end

        accel_next = aabc_pkg::sat24(acc);
        speed_next = aabc_pkg::sat24(spd + W'(accel_next));
    end

    assign take = prod_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            speed_reg   <= '0;
            brake_reg   <= 1'b0;
        end else begin
            if (take) begin
                m_valid_reg <= 1'b1;
                speed_reg   <= speed_next;
                brake_reg   <= brake_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            accel_reg <= accel_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_accel_out = accel_reg;
    assign m_speed_out = speed_reg;
    assign m_braking   = brake_reg;

endmodule
`default_nettype wire

// ----- rtl/core/axis_accel_brake_controller_core.sv -----
// pipeline: the products are formed and registered in the input stage, then the speed
// and brake update is formed combinationally and registered in the result stage
// throughput: one item per cycle while m_ready does not stall the result stage
// reset: synchronous active-low aresetn clears speed, brake flag and both valid
// stages, and loads the configuration registers with their defaults
`default_nettype none
module axis_accel_brake_controller_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [aabc_pkg::IDX_W-1:0]          cfg_index,
    input  wire logic [aabc_pkg::MAG_W-1:0]          cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [aabc_pkg::POS_W-1:0]   s_current_position,
    input  wire logic signed [aabc_pkg::POS_W-1:0]   s_target_position,
    input  wire logic [aabc_pkg::MAG_W-1:0]          s_margin_pos,
    input  wire logic [aabc_pkg::MAG_W-1:0]          s_margin_neg,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [aabc_pkg::POS_W-1:0]        m_accel_out,
    output logic signed [aabc_pkg::POS_W-1:0]        m_speed_out,
    output logic                                     m_braking
);

    aabc_pkg::cfg_t  cfg;
    aabc_pkg::prod_t prod;
    logic            prod_valid;
    logic            take;

    assign cfg_ready = 1'b1;

    aabc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    aabc_prod u_prod (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_current_position (s_current_position),
        .s_target_position  (s_target_position),
        .s_margin_pos       (s_margin_pos),
        .s_margin_neg       (s_margin_neg),
        .cfg                (cfg),
        .take               (take),
        .prod_valid         (prod_valid),
        .prod               (prod)
    );

    aabc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .prod_valid  (prod_valid),
        .prod        (prod),
        .cfg         (cfg),
        .take        (take),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_accel_out (m_accel_out),
        .m_speed_out (m_speed_out),
        .m_braking   (m_braking)
    );

endmodule
`default_nettype wire

// ----- tb/sv/tb_axis_accel_brake_controller_core.sv -----
`default_nettype none
module tb_axis_accel_brake_controller_core;
    timeunit 1ns;
    timeprecision 1ps;

    import aabc_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 11;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 600;
    localparam int CFG_CHUNK       = 150;
    localparam int SETTLE_CYCLES   = 4;

    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7F_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 24'sh80_0000;
    localparam logic [MAG_W-1:0]        MAG_MAX = '1;

    typedef struct {
        logic signed [POS_W-1:0] accel;
        logic signed [POS_W-1:0] speed;
        logic                    braking;
    } motion_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [IDX_W-1:0]          cfg_index = REG_GAIN_POS;
    logic [MAG_W-1:0]          cfg_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [POS_W-1:0]   s_current_position = '0;
    logic signed [POS_W-1:0]   s_target_position = '0;
    logic [MAG_W-1:0]          s_margin_pos = '0;
    logic [MAG_W-1:0]          s_margin_neg = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [POS_W-1:0]   m_accel_out;
    logic signed [POS_W-1:0]   m_speed_out;
    logic                      m_braking;

    cfg_t                      cfg_shadow;
    logic signed [POS_W-1:0]   axis_speed_q;
    logic                      brake_q;
    motion_t                   expected_motion[$];
    int                        mismatch_count = 0;
    int                        snd_idle_pct = 0;
    int                        rcv_idle_pct = 0;
    int unsigned               cycle_count = 0;

    axis_accel_brake_controller_core u_dut (.*);

    initial begin
        forever begin
            #HALF_PERIOD aclk = ~aclk;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        motion_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_motion.size() == 0) begin
                $display("%0t: unexpected item accel %0d speed %0d braking %0b",
                         $time, m_accel_out, m_speed_out, m_braking);
                mismatch_count++;
            end else begin
                want = expected_motion.pop_front();
                if (m_accel_out !== want.accel) begin
                    $display("%0t: accel_out expected %0d actual %0d",
                             $time, want.accel, m_accel_out);
                    mismatch_count++;
                end
                if (m_speed_out !== want.speed) begin
                    $display("%0t: speed_out expected %0d actual %0d",
                             $time, want.speed, m_speed_out);
                    mismatch_count++;
                end
                if (m_braking !== want.braking) begin
                    $display("%0t: braking expected %0b actual %0b",
                             $time, want.braking, m_braking);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic longint q20_mul(input longint a, input longint b);
        return (a * b + 64'sd524288) >>> Q_FRAC;
    endfunction

    function automatic longint clamp_s24(input longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic logic [MAG_W-1:0] rand_mag();
        int w;
        w = $urandom_range(0, MAG_W);
        if (w == 0) return '0;
        return MAG_W'($urandom_range(0, (32'd1 << w) - 1));
    endfunction

    task automatic step_axis_model(input logic signed [POS_W-1:0] cur,
                                   input logic signed [POS_W-1:0] tgt,
                                   input logic [MAG_W-1:0] mp,
                                   input logic [MAG_W-1:0] mn);
        longint  c, t, mpl, mnl, gp, gn, lp, ln;
        longint  spd, err, gain, crawl, acc, d;
        motion_t want;
        c     = cur;
        t     = tgt;
        mpl   = mp;
        mnl   = mn;
        gp    = cfg_shadow.gain_pos;
        gn    = cfg_shadow.gain_neg;
        lp    = cfg_shadow.limit_pos;
        ln    = cfg_shadow.limit_neg;
        spd   = axis_speed_q;
        err   = t - c;
        gain  = 2 * ((err < 0) ? -err : err);
        crawl = q20_mul(err, longint'(CRAWL_COEF));
        acc   = 0;
        if (brake_q) begin
            if (spd > 0) begin
                acc = clamp_s24(-2 * q20_mul(gp, gain));
                if (spd + acc <= 0) brake_q = 1'b0;
            end else if (spd < 0) begin
                acc = clamp_s24(2 * q20_mul(gn, gain));
                if (spd + acc >= 0) brake_q = 1'b0;
            end else begin
                brake_q = 1'b0;
            end
        end else if (t > c) begin
            if (spd > lp) begin
                acc = -q20_mul(gn, gain);
            end else if (t > c + mpl) begin
                acc = q20_mul(gp, gain);
            end else if (spd >= 0) begin
                if (spd > crawl) begin
                    d   = spd - crawl;
                    acc = -((d < gp) ? d : gp);
                end else begin
                    acc = crawl;
                end
            end else begin
                brake_q = 1'b1;
            end
        end else begin
            // equal positions fall through here as negative motion
            if (spd < -ln) begin
                acc = q20_mul(gp, gain);
            end else if (t < c - mnl) begin
                acc = -q20_mul(gn, gain);
            end else if (spd > 0) begin
                brake_q = 1'b1;
            end else if (spd < crawl) begin
                d   = crawl - spd;
                acc = (d < gn) ? d : gn;
            end else begin
                acc = crawl;
            end
        end
        acc          = clamp_s24(acc);
        spd          = clamp_s24(spd + acc);
        axis_speed_q = POS_W'(spd);
        want.accel   = POS_W'(acc);
        want.speed   = POS_W'(spd);
        want.braking = brake_q;
        expected_motion.push_back(want);
    endtask

    task automatic send_tick(input logic signed [POS_W-1:0] cur,
                             input logic signed [POS_W-1:0] tgt,
                             input logic [MAG_W-1:0] mp,
                             input logic [MAG_W-1:0] mn);
        @(negedge aclk);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid            <= 1'b1;
        s_current_position <= cur;
        s_target_position  <= tgt;
        s_margin_pos       <= mp;
        s_margin_neg       <= mn;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        step_axis_model(cur, tgt, mp, mn);
    endtask

    task automatic write_cfg(input logic [IDX_W-1:0] idx, input logic [MAG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_GAIN_POS:  cfg_shadow.gain_pos = val;
            REG_GAIN_NEG:  cfg_shadow.gain_neg = val;
            REG_LIMIT_POS: cfg_shadow.limit_pos = val;
            REG_LIMIT_NEG: cfg_shadow.limit_neg = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_motion.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic randomize_cfg();
        logic [IDX_W-1:0] regs[4];
        logic [MAG_W-1:0] val;
        int               mode;
        regs = '{REG_GAIN_POS, REG_GAIN_NEG, REG_LIMIT_POS, REG_LIMIT_NEG};
        for (int i = 0; i < 4; i++) begin
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                val = '0;
            end else if (mode == 1) begin
                val = MAG_MAX;
            end else if (mode == 2) begin
                val = (regs[i] == REG_GAIN_POS || regs[i] == REG_GAIN_NEG) ?
                      GAIN_RESET : LIMIT_RESET;
            end else begin
                val = rand_mag();
            end
            write_cfg(regs[i], val);
        end
    endtask

    task automatic test_directed_cases();
        send_tick('0, '0, '0, '0);
        send_tick(POS_MIN, POS_MAX, '0, '0);
        send_tick(POS_MIN, POS_MAX, '0, '0);
        send_tick('0, 24'sd100, MAG_MAX, MAG_MAX);
        send_tick(POS_MAX, POS_MIN, '0, '0);
        send_tick(POS_MAX, POS_MIN, '0, '0);
        send_tick(24'sd100, '0, MAG_MAX, MAG_MAX);
        send_tick('0, 24'sd1, '0, '0);
        send_tick(POS_MIN, POS_MAX, '0, '0);
        send_tick(-24'sd100, '0, MAG_MAX, MAG_MAX);
        send_tick('0, 24'sd1, '0, '0);
        send_tick(POS_MIN, POS_MAX, '0, '0);
        send_tick('0, '0, '0, '0);
        send_tick('0, '0, '0, '0);
    endtask

    task automatic test_config_extremes();
        drain_results();
        write_cfg(REG_GAIN_POS, MAG_MAX);
        write_cfg(REG_GAIN_NEG, MAG_MAX);
        write_cfg(REG_LIMIT_POS, MAG_MAX);
        write_cfg(REG_LIMIT_NEG, MAG_MAX);
        repeat (3) send_tick(POS_MIN, POS_MAX, '0, '0);
        send_tick('0, 24'sd100, MAG_MAX, MAG_MAX);
        repeat (3) send_tick(POS_MAX, POS_MIN, '0, '0);
        send_tick(24'sd100, '0, MAG_MAX, MAG_MAX);
        drain_results();
        write_cfg(REG_GAIN_POS, '0);
        write_cfg(REG_GAIN_NEG, '0);
        write_cfg(REG_LIMIT_POS, '0);
        write_cfg(REG_LIMIT_NEG, '0);
        send_tick('0, 24'sd100, MAG_MAX, MAG_MAX);
        send_tick(24'sd100, '0, MAG_MAX, MAG_MAX);
        send_tick(POS_MIN, POS_MAX, '0, '0);
    endtask

    task automatic test_random_tracking(input int n_items, input int snd_pct,
                                        input int rcv_pct);
        int               sent;
        int               cfg_due;
        int               kind;
        int               run_len;
        int               w;
        longint           pos;
        longint           goal;
        logic [MAG_W-1:0] mp;
        logic [MAG_W-1:0] mn;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        sent    = 0;
        cfg_due = 0;
        pos     = 0;
        while (sent < n_items) begin
            if (sent >= cfg_due) begin
                drain_results();
                randomize_cfg();
                cfg_due += CFG_CHUNK;
            end
            kind = $urandom_range(0, 99);
            if (kind < 12) begin
                send_tick(POS_W'($urandom), POS_W'($urandom), MAG_W'($urandom),
                          MAG_W'($urandom));
                sent++;
            end else if (kind < 17) begin
                pos = longint'(POS_W'($urandom)) - (longint'(POS_W'($urandom)) >>> 1);
                pos = clamp_s24(pos);
            end else begin
                // closed loop: the position follows the predicted speed
                run_len = $urandom_range(4, 40);
                w       = $urandom_range(1, POS_W);
                goal    = clamp_s24(pos + longint'($urandom_range(0, (32'd1 << w) - 1))
                                    - (64'sd1 <<< (w - 1)));
                mp      = rand_mag();
                mn      = rand_mag();
                for (int k = 0; k < run_len; k++) begin
                    if ($urandom_range(0, 19) == 0) goal = clamp_s24(2 * pos - goal);
                    send_tick(POS_W'(pos), POS_W'(goal), mp, mn);
                    pos = clamp_s24(pos + longint'(axis_speed_q));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        cfg_shadow.gain_pos  = GAIN_RESET;
        cfg_shadow.gain_neg  = GAIN_RESET;
        cfg_shadow.limit_pos = LIMIT_RESET;
        cfg_shadow.limit_neg = LIMIT_RESET;
        axis_speed_q         = '0;
        brake_q              = 1'b0;
        snd_idle_pct         = 38;
        rcv_idle_pct         = 66;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_config_extremes();
        test_random_tracking(ITEMS_PER_PHASE, 38, 66);
        test_random_tracking(ITEMS_PER_PHASE, 66, 38);
        test_random_tracking(ITEMS_PER_PHASE, 0, 0);
        drain_results();

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire
